FILE: rtl/mipc_pkg.sv
// ----------------------------------------------------------------------------
// Motion/idle power mode controller package
// Shared types, register indexes, clock mode codes and the current table.
// ----------------------------------------------------------------------------
`default_nettype none

package mipc_pkg;

  // Register indexes of the configuration port
  localparam int unsigned CfgIndexWidth = 3;
  localparam logic [CfgIndexWidth-1:0] CFG_MOTION_THRESH      = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_IDLE_TIMEOUT       = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_AUTO_SLEEP_ENABLE  = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_AUTO_SLEEP_TIMEOUT = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_BATTERY_LEVEL      = 3'd4;
  localparam logic [CfgIndexWidth-1:0] CFG_LOW_BATTERY_LIMIT  = 3'd5;
  localparam logic [CfgIndexWidth-1:0] CFG_CHARGER_PRESENT    = 3'd6;

  localparam int unsigned CfgDataWidth = 32;

  // Register reset values
  localparam logic [15:0] RST_MOTION_THRESH      = 16'd128;
  localparam logic [28:0] RST_IDLE_TIMEOUT       = 29'd100;
  localparam logic [31:0] RST_AUTO_SLEEP_TIMEOUT = 32'd30000;
  localparam logic [6:0]  RST_BATTERY_LEVEL      = 7'd100;
  localparam logic [6:0]  RST_LOW_BATTERY_LIMIT  = 7'd15;

  // Estimate reset values
  localparam logic [7:0]  RST_PRESENT_CURRENT = 8'd233;
  localparam logic [23:0] RST_AVERAGE_CURRENT = 24'd763494;

  // Currents in 0.05 mA units
  localparam logic [7:0] CUR_MCU_HIGH = 8'd160;
  localparam logic [7:0] CUR_MCU_MED  = 8'd90;
  localparam logic [7:0] CUR_MCU_LOW  = 8'd40;
  localparam logic [7:0] CUR_RADIO    = 8'd24;
  localparam logic [7:0] CUR_IMU      = 8'd13;
  localparam logic [7:0] CUR_LED      = 8'd20;
  localparam logic [7:0] CUR_OTHER    = 8'd16;

  // Divider register codes
  localparam logic [2:0] DIV_HIGH = 3'd0;
  localparam logic [2:0] DIV_MED  = 3'd1;
  localparam logic [2:0] DIV_LOW  = 3'd7;

  // Reciprocal of 5: floor(y * RECIP5 / 2^34) == floor(y / 5) for any 32-bit y
  localparam logic [31:0] RECIP5       = 32'hCCCC_CCCD;
  localparam int unsigned Recip5Shift  = 34;

  localparam logic [6:0] DUTY_NONE = 7'd100;

  typedef enum logic [1:0] {
    CLK_HIGH = 2'd0,
    CLK_MED  = 2'd1,
    CLK_LOW  = 2'd2
  } clk_mode_e;

  typedef struct packed {
    logic [15:0] motion_thresh;
    logic [28:0] idle_timeout;
    logic        auto_sleep_enable;
    logic [31:0] auto_sleep_timeout;
    logic [6:0]  battery_level;
    logic [6:0]  low_battery_limit;
    logic        charger_present;
  } cfg_t;

  typedef struct packed {
    logic      eval;
    logic      est_load;
    clk_mode_e est_target;
    logic      est_mul;
    logic      est_write;
    logic      div_start;
    logic      div_step;
    logic      finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] plan_upd;
    logic       moving;
    logic       div_last;
  } dp_status_t;

  typedef struct packed {
    logic [1:0]  clock_sel;
    logic [2:0]  clock_divider_code;
    logic        radio_on;
    logic        led_on;
    logic        moving;
    logic        halt_request;
    logic [31:0] idle_ms;
    logic [7:0]  current_estimate;
    logic [23:0] average_estimate;
    logic [6:0]  duty_pct;
  } result_t;

  function automatic logic [7:0] current_for(clk_mode_e mode, logic radio, logic led);
    logic [7:0] cur;
    unique case (mode)
      CLK_HIGH: cur = CUR_MCU_HIGH;
      CLK_MED:  cur = CUR_MCU_MED;
      default:  cur = CUR_MCU_LOW;
    endcase
    if (radio) cur = cur + CUR_RADIO;
    cur = cur + CUR_IMU;
    if (led) cur = cur + CUR_LED;
    cur = cur + CUR_OTHER;
    return cur;
  endfunction

  function automatic logic [2:0] divider_code(clk_mode_e mode);
    logic [2:0] code;
    unique case (mode)
      CLK_HIGH: code = DIV_HIGH;
      CLK_MED:  code = DIV_MED;
      default:  code = DIV_LOW;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/motion_idle_power_mode_controller.sv
// Sequence per sample: up to three current estimate updates (add, reciprocal multiply,
//   write), one divider load, 7 restoring steps of the duty divider, one output load.
// The sequencer handles one sample at a time.
// The result register lets the next sample enter while a result still waits.
// Reset: asynchronous, active low; restores the configuration, mode state and estimate.
// ----------------------------------------------------------------------------
// Motion/idle power mode controller
// Picks the clock mode from gyro motion and idle time, tracks a supply current
// estimate with a moving average and reports the active duty percentage.
// ----------------------------------------------------------------------------
`default_nettype none

module motion_idle_power_mode_controller import mipc_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // Configuration write port
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgIndexWidth-1:0] cfg_index_i,
  input  wire logic [CfgDataWidth-1:0]  cfg_wdata_i,
  // Sample input
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [15:0]              gyro_magnitude_i,
  input  wire logic [31:0]              now_ms_i,
  // Result output
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [1:0]                    clock_sel_o,
  output logic [2:0]                    clock_divider_code_o,
  output logic                          radio_on_o,
  output logic                          led_on_o,
  output logic                          moving_o,
  output logic                          halt_request_o,
  output logic [31:0]                   idle_ms_o,
  output logic [7:0]                    current_estimate_o,
  output logic [23:0]                   average_estimate_o,
  output logic [6:0]                    duty_pct_o
);

  // Configuration registers; the user must write them only while no sample is in flight; the block has no guard for it
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.motion_thresh      <= RST_MOTION_THRESH;
      cfg_q.idle_timeout       <= RST_IDLE_TIMEOUT;
      cfg_q.auto_sleep_enable  <= 1'b0;
      cfg_q.auto_sleep_timeout <= RST_AUTO_SLEEP_TIMEOUT;
      cfg_q.battery_level      <= RST_BATTERY_LEVEL;
      cfg_q.low_battery_limit  <= RST_LOW_BATTERY_LIMIT;
      cfg_q.charger_present    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MOTION_THRESH:      cfg_q.motion_thresh      <= cfg_wdata_i[15:0];
        CFG_IDLE_TIMEOUT:       cfg_q.idle_timeout       <= cfg_wdata_i[28:0];
        CFG_AUTO_SLEEP_ENABLE:  cfg_q.auto_sleep_enable  <= cfg_wdata_i[0];
        CFG_AUTO_SLEEP_TIMEOUT: cfg_q.auto_sleep_timeout <= cfg_wdata_i[31:0];
        CFG_BATTERY_LEVEL:      cfg_q.battery_level      <= cfg_wdata_i[6:0];
        CFG_LOW_BATTERY_LIMIT:  cfg_q.low_battery_limit  <= cfg_wdata_i[6:0];
        CFG_CHARGER_PRESENT:    cfg_q.charger_present    <= cfg_wdata_i[0];
        default: ; // unmapped index: ignore the write
      endcase
    end
  end

  ctrl_cmd_t  cmd;
  dp_status_t status;
  result_t    res;

  // Result register: free when empty or when its transfer completes this edge
  result_t out_q;
  logic    out_valid_q;
  logic    out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  mipc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mipc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_i            (cfg_q),
    .gyro_magnitude_i (gyro_magnitude_i),
    .now_ms_i         (now_ms_i),
    .status_o         (status),
    .res_o            (res)
  );

  // Hold the result until its transfer; load a new one on finish
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.finish) out_q <= res;
  end

  assign out_valid_o          = out_valid_q;
  assign clock_sel_o          = out_q.clock_sel;
  assign clock_divider_code_o = out_q.clock_divider_code;
  assign radio_on_o           = out_q.radio_on;
  assign led_on_o             = out_q.led_on;
  assign moving_o             = out_q.moving;
  assign halt_request_o       = out_q.halt_request;
  assign idle_ms_o            = out_q.idle_ms;
  assign current_estimate_o   = out_q.current_estimate;
  assign average_estimate_o   = out_q.average_estimate;
  assign duty_pct_o           = out_q.duty_pct;

endmodule

`default_nettype wire

FILE: rtl/mipc_dp.sv
// ----------------------------------------------------------------------------
// Motion/idle power mode datapath
// Mode state, idle timing, current estimate with moving average, duty divider.
// ----------------------------------------------------------------------------
`default_nettype none

module mipc_dp import mipc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ctrl_cmd_t   cmd_i,
  input  wire cfg_t        cfg_i,
  input  wire logic [15:0] gyro_magnitude_i,
  input  wire logic [31:0] now_ms_i,
  output dp_status_t       status_o,
  output result_t          res_o
);

  clk_mode_e   clock_q;
  logic        radio_q;
  logic        led_q;
  logic [31:0] last_motion_q;
  logic [31:0] active_cnt_q;
  logic [31:0] idle_cnt_q;
  logic [7:0]  present_q;
  logic [23:0] avg_q;
  logic [2:0]  cnt_q;

  logic        moving_q;
  logic        halt_q;
  logic [31:0] idle_q;
  logic [28:0] acc_q;
  logic [58:0] prod_q;
  logic [38:0] rem_q;
  logic [32:0] den_q;
  logic [6:0]  quo_q;
  logic        zero_q;

  // Plan of the sample
  logic        moving;
  logic [31:0] idle_time;
  logic [32:0] timeout_x10;
  logic        upd0, upd1, upd2;
  clk_mode_e   clk_after0;
  logic        halt;
  logic        batt_low;

  always_comb begin
    moving      = gyro_magnitude_i > cfg_i.motion_thresh;
    idle_time   = now_ms_i - last_motion_q;
    timeout_x10 = {1'b0, cfg_i.idle_timeout, 3'b000} + {3'b000, cfg_i.idle_timeout, 1'b0};
    batt_low    = (cfg_i.battery_level < cfg_i.low_battery_limit) && !cfg_i.charger_present;
    if (moving) begin
      upd0 = clock_q != CLK_HIGH;
    end else begin
      upd0 = (idle_time > {3'b000, cfg_i.idle_timeout}) && (clock_q == CLK_HIGH);
    end
    if (upd0) begin
      clk_after0 = moving ? CLK_HIGH : CLK_MED;
    end else begin
      clk_after0 = clock_q;
    end
    upd1 = !moving && ({1'b0, idle_time} > timeout_x10) && (clk_after0 != CLK_LOW);
    upd2 = batt_low;
    halt = !moving && cfg_i.auto_sleep_enable && (idle_time > cfg_i.auto_sleep_timeout);
  end

  // Estimate step
  logic [7:0]  est_cur;
  logic [28:0] acc_d;
  always_comb begin
    est_cur = current_for(cmd_i.est_target, radio_q, led_q);
    acc_d   = {1'b0, avg_q, 4'b0000} + {4'b0000, avg_q, 1'b0} + {5'b00000, avg_q}
            + {5'b00000, est_cur, 16'h0000};
  end

  // Duty divider step
  logic [39:0] shifted;
  logic        fits;
  logic [39:0] rem_sub;
  always_comb begin
    shifted = {7'b0000000, den_q} << cnt_q;
    fits    = {1'b0, rem_q} >= shifted;
    rem_sub = {1'b0, rem_q} - shifted;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q       <= CLK_HIGH;
      radio_q       <= 1'b1;
      led_q         <= 1'b1;
      last_motion_q <= '0;
      active_cnt_q  <= '0;
      idle_cnt_q    <= '0;
      present_q     <= RST_PRESENT_CURRENT;
      avg_q         <= RST_AVERAGE_CURRENT;
      cnt_q         <= '0;
    end else begin
      if (cmd_i.eval) begin
        if (moving) begin
          last_motion_q <= now_ms_i;
          radio_q       <= 1'b1;
          active_cnt_q  <= active_cnt_q + 32'd1;
        end else begin
          idle_cnt_q <= idle_cnt_q + 32'd1;
        end
      end
      if (cmd_i.est_load) begin
        clock_q   <= cmd_i.est_target;
        present_q <= est_cur;
      end
      if (cmd_i.est_write) begin
        avg_q <= prod_q[Recip5Shift+23:Recip5Shift];
      end
      if (cmd_i.div_start) begin
        cnt_q <= 3'd6;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - 3'd1;
      end
      // Drop the LED after the last recompute of the sample
      if (cmd_i.finish && batt_low) begin
        led_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      moving_q <= moving;
      halt_q   <= halt;
      idle_q   <= moving ? 32'd0 : idle_time;
    end
    if (cmd_i.est_load) begin
      acc_q <= acc_d;
    end
    if (cmd_i.est_mul) begin
      prod_q <= 59'(acc_q[28:2]) * 59'(RECIP5);
    end
    if (cmd_i.div_start) begin
      rem_q  <= {1'b0, active_cnt_q, 6'b000000} + {2'b00, active_cnt_q, 5'b00000}
              + {5'b00000, active_cnt_q, 2'b00};
      den_q  <= {1'b0, active_cnt_q} + {1'b0, idle_cnt_q};
      zero_q <= (active_cnt_q == 32'd0) && (idle_cnt_q == 32'd0);
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      if (fits) begin
        rem_q        <= rem_sub[38:0];
        quo_q[cnt_q] <= 1'b1;
      end
    end
  end

  always_comb begin
    status_o.plan_upd = {upd2, upd1, upd0};
    status_o.moving   = moving;
    status_o.div_last = cnt_q == 3'd0;

    res_o.clock_sel          = clock_q;
    res_o.clock_divider_code = divider_code(clock_q);
    res_o.radio_on           = radio_q;
    res_o.led_on             = led_q & ~batt_low;
    res_o.moving             = moving_q;
    res_o.halt_request       = halt_q;
    res_o.idle_ms            = idle_q;
    res_o.current_estimate   = present_q;
    res_o.average_estimate   = avg_q;
    res_o.duty_pct           = zero_q ? DUTY_NONE : quo_q;
  end

endmodule

`default_nettype wire

FILE: rtl/mipc_ctrl.sv
// ----------------------------------------------------------------------------
// Motion/idle power mode sequencer
// Walks one sample through its estimate updates, the duty division and output.
// ----------------------------------------------------------------------------
`default_nettype none

module mipc_ctrl import mipc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       out_free_i,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL,
    S_WRITE,
    S_DIV,
    S_FINISH
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] pend_q, pend_d;
  logic       mov_q, mov_d;

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    mov_d      = mov_q;
    cmd_o      = '0;
    cmd_o.est_target = CLK_LOW;
    in_stall_o = state_q != S_IDLE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.eval = 1'b1;
          pend_d     = status_i.plan_upd;
          mov_d      = status_i.moving;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (pend_q[0]) begin
          cmd_o.est_load   = 1'b1;
          cmd_o.est_target = mov_q ? CLK_HIGH : CLK_MED;
          pend_d[0]        = 1'b0;
          state_d          = S_MUL;
        end else if (pend_q[1]) begin
          cmd_o.est_load = 1'b1;
          pend_d[1]      = 1'b0;
          state_d        = S_MUL;
        end else if (pend_q[2]) begin
          cmd_o.est_load = 1'b1;
          pend_d[2]      = 1'b0;
          state_d        = S_MUL;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_MUL: begin
        cmd_o.est_mul = 1'b1;
        state_d       = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.est_write = 1'b1;
        state_d         = S_DISPATCH;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free_i) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= '0;
      mov_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      mov_q   <= mov_d;
    end
  end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Motion/idle power mode controller testbench
// Drives gyro samples through the valid/stall input channel, predicts each
// result with a cycle-free model of the mode, estimate and duty logic, and
// compares every result field against the oldest prediction. Both channels
// idle and stall at random; registers change only while the block is drained.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mipc_pkg::*;

  // Index that decodes to no register; writes to it must be ignored
  localparam logic [CfgIndexWidth-1:0] CfgUnusedIndex = 3'd7;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxWait = 11;
  localparam int unsigned RandomPhases = 13;
  localparam int unsigned PhaseItems = 100;

  typedef struct {
    logic [15:0] gyro;
    logic [31:0] stamp;
  } sample_t;

  // Block ports; the inputs are known from time zero
  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index_i = CFG_MOTION_THRESH;
  logic [CfgDataWidth-1:0]  cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [15:0]              gyro_magnitude_i = '0;
  logic [31:0]              now_ms_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [1:0]               clock_sel_o;
  logic [2:0]               clock_divider_code_o;
  logic                     radio_on_o;
  logic                     led_on_o;
  logic                     moving_o;
  logic                     halt_request_o;
  logic [31:0]              idle_ms_o;
  logic [7:0]               current_estimate_o;
  logic [23:0]              average_estimate_o;
  logic [6:0]               duty_pct_o;

  // Register copy seen by the predictor
  cfg_t        settings;

  // Predicted block state
  clk_mode_e   mode;
  logic        radio_st;
  logic        led_st;
  logic [31:0] last_motion;
  logic [31:0] idle_span;
  logic [7:0]  present_amps;
  logic [23:0] average_amps;
  logic [31:0] active_n;
  logic [31:0] idle_n;

  // Stimulus and checking bookkeeping
  sample_t     pending_samples[$];
  result_t     predicted_results[$];
  logic        sample_took = 1'b0;
  logic        result_took = 1'b0;
  bit          sender_steady = 1'b0;
  bit          receiver_steady = 1'b0;
  int unsigned send_gap = 0;
  int unsigned hold_left = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic [31:0] gen_cursor = '0;
  logic [31:0] gen_motion = '0;

  motion_idle_power_mode_controller dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .gyro_magnitude_i    (gyro_magnitude_i),
    .now_ms_i            (now_ms_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .clock_sel_o         (clock_sel_o),
    .clock_divider_code_o(clock_divider_code_o),
    .radio_on_o          (radio_on_o),
    .led_on_o            (led_on_o),
    .moving_o            (moving_o),
    .halt_request_o      (halt_request_o),
    .idle_ms_o           (idle_ms_o),
    .current_estimate_o  (current_estimate_o),
    .average_estimate_o  (average_estimate_o),
    .duty_pct_o          (duty_pct_o)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic void reset_model();
    settings.motion_thresh      = RST_MOTION_THRESH;
    settings.idle_timeout       = RST_IDLE_TIMEOUT;
    settings.auto_sleep_enable  = 1'b0;
    settings.auto_sleep_timeout = RST_AUTO_SLEEP_TIMEOUT;
    settings.battery_level      = RST_BATTERY_LEVEL;
    settings.low_battery_limit  = RST_LOW_BATTERY_LIMIT;
    settings.charger_present    = 1'b0;
    mode         = CLK_HIGH;
    radio_st     = 1'b1;
    led_st       = 1'b1;
    last_motion  = '0;
    idle_span    = '0;
    present_amps = RST_PRESENT_CURRENT;
    average_amps = RST_AVERAGE_CURRENT;
    active_n     = '0;
    idle_n       = '0;
  endfunction

  // Sum the supply currents for the present mode, then take one step of the
  // moving average: 19/20 of the old value plus 1/20 of the new, truncated.
  function automatic void refresh_estimate();
    logic [7:0]  amps;
    logic [63:0] acc;
    logic [63:0] quot;
    case (mode)
      CLK_HIGH: amps = CUR_MCU_HIGH;
      CLK_MED:  amps = CUR_MCU_MED;
      default:  amps = CUR_MCU_LOW;
    endcase
    if (radio_st) amps = amps + CUR_RADIO;
    amps = amps + CUR_IMU;
    if (led_st) amps = amps + CUR_LED;
    amps = amps + CUR_OTHER;
    present_amps = amps;
    acc  = 64'(average_amps) * 64'd19 + (64'(amps) << 16);
    quot = acc / 64'd20;
    average_amps = quot[23:0];
  endfunction

  function automatic void switch_mode(clk_mode_e target);
    mode = target;
    refresh_estimate();
  endfunction

  function automatic result_t predict_power_state(logic [15:0] gyro, logic [31:0] stamp);
    result_t     r;
    logic        halt;
    logic        in_motion;
    logic [63:0] total;
    logic [63:0] duty;
    halt = 1'b0;
    in_motion = (gyro > settings.motion_thresh);
    if (in_motion) begin
      last_motion = stamp;
      idle_span = '0;
      if (mode != CLK_HIGH) switch_mode(CLK_HIGH);
      if (!radio_st) begin
        radio_st = 1'b1;
        refresh_estimate();
      end
      active_n = active_n + 32'd1;
    end else begin
      // Idle time wraps with the tick; the tenfold limit is compared unwrapped
      idle_span = stamp - last_motion;
      if (idle_span > 32'(settings.idle_timeout) && mode == CLK_HIGH) switch_mode(CLK_MED);
      if (64'(idle_span) > 64'(settings.idle_timeout) * 64'd10 && mode != CLK_LOW)
        switch_mode(CLK_LOW);
      if (settings.auto_sleep_enable && idle_span > settings.auto_sleep_timeout) halt = 1'b1;
      idle_n = idle_n + 32'd1;
    end
    // Low battery forces the low clock every time, then drops the LED for good
    if (settings.battery_level < settings.low_battery_limit && !settings.charger_present) begin
      switch_mode(CLK_LOW);
      led_st = 1'b0;
    end
    total = 64'(active_n) + 64'(idle_n);
    duty  = (total == 64'd0) ? 64'(DUTY_NONE) : (64'(active_n) * 64'd100) / total;

    r.clock_sel = mode;
    case (mode)
      CLK_HIGH: r.clock_divider_code = DIV_HIGH;
      CLK_MED:  r.clock_divider_code = DIV_MED;
      default:  r.clock_divider_code = DIV_LOW;
    endcase
    r.radio_on         = radio_st;
    r.led_on           = led_st;
    r.moving           = in_motion;
    r.halt_request     = halt;
    r.idle_ms          = idle_span;
    r.current_estimate = present_amps;
    r.average_estimate = average_amps;
    r.duty_pct         = duty[6:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input channel: driver advances on falling edges, transfers seen on rising
  // --------------------------------------------------------------------------

  // Hold the payload while stalled; after a transfer, wait out the drawn gap
  // before presenting the next sample.
  always @(negedge clk_i) begin : sample_driver
    sample_t next_item;
    if (rst_ni && (!in_valid_i || sample_took)) begin
      if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap = send_gap - 1;
      end else if (pending_samples.size() != 0) begin
        next_item = pending_samples.pop_front();
        gyro_magnitude_i <= next_item.gyro;
        now_ms_i         <= next_item.stamp;
        in_valid_i       <= 1'b1;
        send_gap = sender_steady ? 0 : $urandom_range(0, MaxWait);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Predict at the transfer itself so the queue order matches acceptance order
  always @(posedge clk_i) begin : sample_monitor
    sample_took <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o)
      predicted_results.push_back(predict_power_state(gyro_magnitude_i, now_ms_i));
  end

  // --------------------------------------------------------------------------
  // Output channel: stall drawn per result, compare on each transfer
  // --------------------------------------------------------------------------

  // Count the stall down only while a result is offered, so it lands on results
  always @(negedge clk_i) begin : stall_driver
    if (rst_ni) begin
      if (result_took) hold_left = receiver_steady ? 0 : $urandom_range(0, MaxWait);
      out_stall_i <= (hold_left != 0);
      if (hold_left != 0 && out_valid_o) hold_left = hold_left - 1;
    end
  end

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_monitor
    result_t want;
    result_took <= rst_ni && out_valid_o && !out_stall_i;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_results.size() == 0) begin
        $error("result transfer with no sample outstanding");
        mismatch_count++;
      end else begin
        want = predicted_results.pop_front();
        compare_field("clock_sel", 32'(want.clock_sel), 32'(clock_sel_o));
        compare_field("clock_divider_code", 32'(want.clock_divider_code),
                      32'(clock_divider_code_o));
        compare_field("radio_on", 32'(want.radio_on), 32'(radio_on_o));
        compare_field("led_on", 32'(want.led_on), 32'(led_on_o));
        compare_field("moving", 32'(want.moving), 32'(moving_o));
        compare_field("halt_request", 32'(want.halt_request), 32'(halt_request_o));
        compare_field("idle_ms", want.idle_ms, idle_ms_o);
        compare_field("current_estimate", 32'(want.current_estimate),
                      32'(current_estimate_o));
        compare_field("average_estimate", 32'(want.average_estimate),
                      32'(average_estimate_o));
        compare_field("duty_pct", 32'(want.duty_pct), 32'(duty_pct_o));
      end
    end
  end

  // Drop the run if it stalls far beyond the slowest legal schedule
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Write one register at a falling edge; the predictor copy follows at once,
  // which is safe because writes only happen with the block drained.
  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_MOTION_THRESH:      settings.motion_thresh      = value[15:0];
      CFG_IDLE_TIMEOUT:       settings.idle_timeout       = value[28:0];
      CFG_AUTO_SLEEP_ENABLE:  settings.auto_sleep_enable  = value[0];
      CFG_AUTO_SLEEP_TIMEOUT: settings.auto_sleep_timeout = value;
      CFG_BATTERY_LEVEL:      settings.battery_level      = value[6:0];
      CFG_LOW_BATTERY_LIMIT:  settings.low_battery_limit  = value[6:0];
      CFG_CHARGER_PRESENT:    settings.charger_present    = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_sample(logic [15:0] gyro, logic [31:0] stamp);
    sample_t s;
    s.gyro  = gyro;
    s.stamp = stamp;
    pending_samples.push_back(s);
  endtask

  // Hold off until every queued sample has transferred and every result has
  // come back, then let the sequencer settle before any register write.
  task automatic wait_for_drain();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_samples.size() != 0 || in_valid_i || predicted_results.size() != 0);
    repeat (25) @(posedge clk_i);
  endtask

  // Build a sample whose tick lands near the interesting idle boundaries
  // measured from the last motion this generator produced.
  task automatic push_random();
    logic [15:0] gyro;
    logic [31:0] span;
    logic [31:0] nudge;
    logic [31:0] stamp;
    int unsigned thr;
    thr   = settings.motion_thresh;
    nudge = $urandom_range(0, 2) - 1;
    case ($urandom_range(0, 9))
      0, 1:    gyro = (thr == 65535) ? 16'hFFFF : 16'($urandom_range(thr + 1, 65535));
      2:       gyro = 16'($urandom);
      3:       gyro = 16'(thr);
      default: gyro = 16'($urandom_range(0, thr));
    endcase
    case ($urandom_range(0, 9))
      0, 1:    span = $urandom_range(0, 40);
      2:       span = 32'(settings.idle_timeout) + nudge;
      3:       span = 32'(64'(settings.idle_timeout) * 64'd10) + nudge;
      4:       span = settings.auto_sleep_timeout + nudge;
      5:       span = $urandom;
      default: span = (gen_cursor - gen_motion) + $urandom_range(0, 300);
    endcase
    stamp = gen_motion + span;
    gen_cursor = stamp;
    if (32'(gyro) > thr) gen_motion = stamp;
    push_sample(gyro, stamp);
  endtask

  // Rewrite every register; without allow_low the battery never forces the
  // low clock, since that switches the LED off until reset.
  task automatic shuffle_settings(bit allow_low);
    logic [6:0] lim;
    logic [6:0] lvl;
    logic       chg;
    case ($urandom_range(0, 4))
      0:       write_reg(CFG_MOTION_THRESH, 32'h0);
      1:       write_reg(CFG_MOTION_THRESH, 32'hFFFF);
      2:       write_reg(CFG_MOTION_THRESH, $urandom_range(1, 600));
      default: write_reg(CFG_MOTION_THRESH, $urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 5))
      0:       write_reg(CFG_IDLE_TIMEOUT, 32'h0);
      1:       write_reg(CFG_IDLE_TIMEOUT, 32'h1);
      2:       write_reg(CFG_IDLE_TIMEOUT, 32'h1FFF_FFFF);
      3:       write_reg(CFG_IDLE_TIMEOUT, 32'd400000000);
      default: write_reg(CFG_IDLE_TIMEOUT, $urandom_range(2, 3000));
    endcase
    write_reg(CFG_AUTO_SLEEP_ENABLE, $urandom_range(0, 1));
    case ($urandom_range(0, 4))
      0:       write_reg(CFG_AUTO_SLEEP_TIMEOUT, 32'h0);
      1:       write_reg(CFG_AUTO_SLEEP_TIMEOUT, 32'hFFFF_FFFF);
      2:       write_reg(CFG_AUTO_SLEEP_TIMEOUT, $urandom);
      default: write_reg(CFG_AUTO_SLEEP_TIMEOUT, $urandom_range(0, 40000));
    endcase
    lim = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(101, 127)) : 7'($urandom_range(0, 100));
    if (allow_low) begin
      lvl = 7'($urandom_range(0, 127));
      chg = 1'($urandom_range(0, 1));
    end else if ($urandom_range(0, 2) == 0) begin
      lvl = 7'($urandom_range(0, 127));
      chg = 1'b1;
    end else begin
      lvl = 7'($urandom_range(lim, 127));
      chg = 1'b0;
    end
    write_reg(CFG_CHARGER_PRESENT, 32'(chg));
    write_reg(CFG_LOW_BATTERY_LIMIT, 32'(lim));
    write_reg(CFG_BATTERY_LEVEL, 32'(lvl));
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------

  initial begin : sequencer
    int unsigned phase;
    reset_model();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: threshold 128, timeout 100, auto sleep off
    push_sample(16'h0000, 32'h0000_0000);   // no motion at tick zero
    push_sample(16'hFFFF, 32'hFFFF_FFFF);   // largest gyro and tick
    push_sample(16'd129, 32'd5);            // just above the threshold
    push_sample(16'd128, 32'd105);          // at the threshold, idle equals timeout
    push_sample(16'd0, 32'd106);            // one past the timeout: medium clock
    push_sample(16'd0, 32'd1105);           // past ten timeouts: low clock
    push_sample(16'h8000, 32'd2000);        // motion restores the high clock
    push_sample(16'd0, 32'd7000);           // high straight to low in one sample
    push_sample(16'd1, 32'd1000);           // tick behind last motion wraps
    wait_for_drain();

    // Long timeout: ten times the largest timeout never fits in 32 bits
    write_reg(CfgUnusedIndex, 32'hFFFF_FFFF);
    write_reg(CFG_MOTION_THRESH, 32'h0);
    write_reg(CFG_IDLE_TIMEOUT, 32'h1FFF_FFFF);
    write_reg(CFG_AUTO_SLEEP_ENABLE, 32'h1);
    write_reg(CFG_AUTO_SLEEP_TIMEOUT, 32'h0);
    push_sample(16'd1, 32'd50);
    push_sample(16'd0, 32'd51);             // halt on the first idle millisecond
    push_sample(16'd0, 32'd50 + 32'h2000_0000);
    push_sample(16'd0, 32'd50 + 32'hFFFF_FFF0);
    wait_for_drain();

    // Zero timeout and the largest auto sleep timeout
    write_reg(CFG_IDLE_TIMEOUT, 32'h0);
    write_reg(CFG_AUTO_SLEEP_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(CFG_BATTERY_LEVEL, 32'd127);
    write_reg(CFG_LOW_BATTERY_LIMIT, 32'd100);
    push_sample(16'd2, 32'd100);
    push_sample(16'd0, 32'd100);            // zero idle stays high
    push_sample(16'd0, 32'd101);
    push_sample(16'd0, 32'd99);             // idle of all ones, still no halt
    wait_for_drain();

    // Charging suppresses the low battery override
    write_reg(CFG_CHARGER_PRESENT, 32'h1);
    write_reg(CFG_BATTERY_LEVEL, 32'd3);
    write_reg(CFG_LOW_BATTERY_LIMIT, 32'd15);
    push_sample(16'd9, 32'd500);
    push_sample(16'd0, 32'd520);
    wait_for_drain();

    for (phase = 0; phase < RandomPhases; phase++) begin
      shuffle_settings(1'b0);
      sender_steady   = ($urandom_range(0, 3) == 0);
      receiver_steady = ($urandom_range(0, 3) == 0);
      repeat (PhaseItems) push_random();
      wait_for_drain();
    end

    // Low battery last: the LED goes off and stays off until reset
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
    write_reg(CFG_MOTION_THRESH, 32'd128);
    write_reg(CFG_IDLE_TIMEOUT, 32'd100);
    write_reg(CFG_CHARGER_PRESENT, 32'h0);
    write_reg(CFG_LOW_BATTERY_LIMIT, 32'd15);
    write_reg(CFG_BATTERY_LEVEL, 32'd15);
    push_sample(16'd200, 32'd10);           // level equal to limit: no override
    wait_for_drain();
    write_reg(CFG_BATTERY_LEVEL, 32'd14);
    push_sample(16'd0, 32'd20);             // forced low, LED off
    push_sample(16'd0, 32'd30);             // already low, estimate still steps
    push_sample(16'd300, 32'd40);           // motion, then forced low again
    wait_for_drain();
    write_reg(CFG_CHARGER_PRESENT, 32'h1);
    push_sample(16'd300, 32'd50);           // high clock back, LED stays off
    wait_for_drain();

    for (phase = 0; phase < 2; phase++) begin
      shuffle_settings(1'b1);
      repeat (PhaseItems / 2) push_random();
      wait_for_drain();
    end

    if (mismatch_count == 0 && predicted_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/mipc_pkg.sv
rtl/mipc_dp.sv
rtl/mipc_ctrl.sv
rtl/motion_idle_power_mode_controller.sv
tb/testbench.sv
